### rtl/core/gpio_edge_event_dispatcher_macros.svh
// assertion helpers shared by the dispatcher modules
`ifndef GPIO_EDGE_EVENT_DISPATCHER_MACROS_SVH
`define GPIO_EDGE_EVENT_DISPATCHER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GED_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GED_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ged_pkg.sv
package ged_pkg;

  // field widths of the channels
  localparam int KIND_W = 3;
  localparam int PORT_W = 2;
  localparam int PIN_W  = 5;
  localparam int ID_W   = 6;
  localparam int WORD_W = 32;
  localparam int CODE_W = 8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_MAP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EVENTS = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOGGLE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic bit_clr;
    logic bit_inc;
    logic commit;
    logic flush;
  } ged_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_scan;
    logic item_ok;
    logic bit_active;
    logic bit_last;
    logic out_free;
    logic pend_vld;
  } ged_sts_t;

endpackage

### rtl/core/ged_if.sv
// input item channel
interface ged_in_if;
  import ged_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PORT_W-1:0] port;
  logic [PIN_W-1:0]  pin;
  logic [ID_W-1:0]   id;
  logic              value;
  logic [WORD_W-1:0] status_bits;
  logic [WORD_W-1:0] level_bits;
  logic [CODE_W-1:0] up_code;
  logic [CODE_W-1:0] dn_code;
  modport source (output valid, kind, port, pin, id, value, status_bits, level_bits,
                  up_code, dn_code, input ready);
  modport sink (input valid, kind, port, pin, id, value, status_bits, level_bits,
                up_code, dn_code, output ready);
endinterface

// result channel
interface ged_out_if;
  import ged_pkg::*;
  logic              valid;
  logic              ready;
  logic              has_event;
  logic [CODE_W-1:0] event_code;
  logic              level;
  logic [PORT_W-1:0] drive_port;
  logic [PIN_W-1:0]  drive_pin;
  logic              last;
  modport source (output valid, has_event, event_code, level, drive_port, drive_pin, last,
                  input ready);
  modport sink (input valid, has_event, event_code, level, drive_port, drive_pin, last,
                output ready);
endinterface

// none-code register write channel
interface ged_cfg_if;
  import ged_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/ged_ctrl.sv
`include "gpio_edge_event_dispatcher_macros.svh"

module ged_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ged_pkg::ged_sts_t sts,
  output ged_pkg::ged_cmd_t cmd
);
  import ged_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_PMAP  = 3'd3;
  localparam logic [2:0] ST_EXE   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.item_ok) begin
          state_nxt = ST_IDLE;
        end else if (sts.is_scan) begin
          cmd.bit_clr = 1'b1;
          state_nxt   = ST_SCAN;
        end else begin
          state_nxt = ST_EXE;
        end
      end
      ST_SCAN: begin
        if (sts.bit_active) begin
          state_nxt = ST_PMAP;
        end else if (sts.bit_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.bit_inc = 1'b1;
        end
      end
      ST_PMAP: begin
        state_nxt = ST_EXE;
      end
      ST_EXE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          if (sts.is_scan && !sts.bit_last) begin
            cmd.bit_inc = 1'b1;
            state_nxt   = ST_SCAN;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_vld) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `GED_ASSERT_SAME(a_commit_free, clk, rst_n, cmd.commit || cmd.flush, sts.out_free, "result word issued while output slot busy")
  `GED_ASSERT_SAME(a_inc_not_last, clk, rst_n, cmd.bit_inc, !sts.bit_last, "scan index stepped past last pin")

endmodule

### rtl/core/ged_dp.sv
`include "gpio_edge_event_dispatcher_macros.svh"

module ged_dp #(
  parameter int NUM_LINES     = 64,
  parameter int NUM_PORTS     = 4,
  parameter int PINS_PER_PORT = 32,
  parameter int CODE_WIDTH    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ged_pkg::ged_cmd_t          cmd,
  output ged_pkg::ged_sts_t          sts,
  input  logic [ged_pkg::KIND_W-1:0] in_kind,
  input  logic [ged_pkg::PORT_W-1:0] in_port,
  input  logic [ged_pkg::PIN_W-1:0]  in_pin,
  input  logic [ged_pkg::ID_W-1:0]   in_id,
  input  logic                       in_value,
  input  logic [ged_pkg::WORD_W-1:0] in_status_bits,
  input  logic [ged_pkg::WORD_W-1:0] in_level_bits,
  input  logic [ged_pkg::CODE_W-1:0] in_up_code,
  input  logic [ged_pkg::CODE_W-1:0] in_dn_code,
  input  logic                       cfg_valid,
  input  logic [ged_pkg::CODE_W-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_has_event,
  output logic [ged_pkg::CODE_W-1:0] out_event_code,
  output logic                       out_level,
  output logic [ged_pkg::PORT_W-1:0] out_drive_port,
  output logic [ged_pkg::PIN_W-1:0]  out_drive_pin,
  output logic                       out_last
);
  import ged_pkg::*;

  localparam int LINE_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int SLOTS   = NUM_PORTS * PINS_PER_PORT;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIT_W   = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;
  localparam int ENTRY_W = 1 + 2 * CODE_WIDTH + PORT_W + PIN_W;

  // latched item
  logic [KIND_W-1:0]     kind_r;
  logic [PORT_W-1:0]     port_r;
  logic [PIN_W-1:0]      pin_r;
  logic [ID_W-1:0]       id_r;
  logic                  value_r;
  logic [WORD_W-1:0]     status_r;
  logic [WORD_W-1:0]     level_r;
  logic [CODE_WIDTH-1:0] up_r;
  logic [CODE_WIDTH-1:0] dn_r;
  logic [CODE_WIDTH-1:0] none_code_r;

  logic [WORD_W-1:0] up_ext;
  logic [WORD_W-1:0] dn_ext;
  logic [WORD_W-1:0] cfg_ext;

  assign up_ext  = WORD_W'(in_up_code);
  assign dn_ext  = WORD_W'(in_dn_code);
  assign cfg_ext = WORD_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      port_r   <= in_port;
      pin_r    <= in_pin;
      id_r     <= in_id;
      value_r  <= in_value;
      status_r <= in_status_bits;
      level_r  <= in_level_bits;
      up_r     <= up_ext[CODE_WIDTH-1:0];
      dn_r     <= dn_ext[CODE_WIDTH-1:0];
    end
  end

  // none-code register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      none_code_r <= '0;
    end else if (cfg_valid) begin
      none_code_r <= cfg_ext[CODE_WIDTH-1:0];
    end
  end

  // item range checks
  logic is_scan;
  logic kind_known;
  logic port_ok;
  logic pin_ok;
  logic id_ok;
  logic item_ok;

  assign is_scan = (kind_r == KIND_SCAN);
  assign port_ok = (WORD_W'(port_r) < WORD_W'(NUM_PORTS));
  assign pin_ok  = (WORD_W'(pin_r) < WORD_W'(PINS_PER_PORT));
  assign id_ok   = (WORD_W'(id_r) < WORD_W'(NUM_LINES));

  always_comb begin
    case (kind_r)
      KIND_MAP, KIND_EVENTS, KIND_WRITE, KIND_TOGGLE, KIND_READ: kind_known = 1'b1;
      default: kind_known = 1'b0;
    endcase
  end

  always_comb begin
    if (is_scan) begin
      item_ok = port_ok;
    end else begin
      item_ok = kind_known && id_ok && ((kind_r != KIND_MAP) || (port_ok && pin_ok));
    end
  end

  // scan bit index
  logic [BIT_W-1:0] bit_r;
  logic [BIT_W-1:0] bit_nxt;
  logic             bit_last;

  always_comb begin
    bit_nxt = bit_r;
    if (cmd.bit_clr) begin
      bit_nxt = '0;
    end else if (cmd.bit_inc) begin
      bit_nxt = bit_r + BIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign bit_last = (WORD_W'(bit_r) == WORD_W'(PINS_PER_PORT - 1));

  // pin map slot, from the scan index or the map item's pin
  logic [WORD_W-1:0] slot_wide;
  logic [SLOT_W-1:0] slot;
  logic [WORD_W-1:0] id_wide;
  logic [LINE_W-1:0] id_line;

  assign slot_wide = WORD_W'(port_r) * WORD_W'(PINS_PER_PORT)
                   + (is_scan ? WORD_W'(bit_r) : WORD_W'(pin_r));
  assign slot      = slot_wide[SLOT_W-1:0];
  assign id_wide   = WORD_W'(id_r);
  assign id_line   = id_wide[LINE_W-1:0];

  // pin map memory with valid bits
  logic [LINE_W-1:0] pmap_mem [SLOTS];
  logic [LINE_W-1:0] pmap_rd_r;
  logic [SLOTS-1:0]  pmap_vld_r;
  logic              pmap_we;

  assign pmap_we = cmd.commit && (kind_r == KIND_MAP);

  always_ff @(posedge clk) begin
    if (pmap_we) begin
      pmap_mem[slot] <= id_line;
    end
    pmap_rd_r <= pmap_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmap_vld_r <= '0;
    end else if (pmap_we) begin
      pmap_vld_r[slot] <= 1'b1;
    end
  end

  // line memory: level, rise code, fall code, port, pin
  logic [ENTRY_W-1:0]   line_mem [NUM_LINES];
  logic [ENTRY_W-1:0]   line_rd_r;
  logic [NUM_LINES-1:0] line_vld_r;
  logic [LINE_W-1:0]    line_addr;
  logic [ENTRY_W-1:0]   cur_entry;
  logic [ENTRY_W-1:0]   new_entry;
  logic                 line_we;

  assign line_addr = is_scan ? pmap_rd_r : id_line;
  assign cur_entry = line_vld_r[line_addr] ? line_rd_r : '0;
  assign line_we   = cmd.commit;

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_addr] <= new_entry;
    end
    line_rd_r <= line_mem[line_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vld_r <= '0;
    end else if (line_we) begin
      line_vld_r[line_addr] <= 1'b1;
    end
  end

  // line update
  logic                  old_lvl;
  logic [CODE_WIDTH-1:0] old_rise;
  logic [CODE_WIDTH-1:0] old_fall;
  logic [PORT_W-1:0]     old_port;
  logic [PIN_W-1:0]      old_pin;
  logic                  new_lvl;
  logic [CODE_WIDTH-1:0] new_rise;
  logic [CODE_WIDTH-1:0] new_fall;
  logic [PORT_W-1:0]     new_port;
  logic [PIN_W-1:0]      new_pin;
  logic                  upd;
  logic                  rise_e;
  logic                  fall_e;
  logic                  ev;
  logic [WORD_W-1:0]     code_wide;
  logic [CODE_W-1:0]     ev_code;
  logic                  has_result;

  assign {old_lvl, old_rise, old_fall, old_port, old_pin} = cur_entry;

  always_comb begin
    new_lvl  = old_lvl;
    new_rise = old_rise;
    new_fall = old_fall;
    new_port = old_port;
    new_pin  = old_pin;
    upd      = 1'b0;
    case (kind_r)
      KIND_MAP: begin
        new_lvl  = value_r;
        new_rise = none_code_r;
        new_fall = none_code_r;
        new_port = port_r;
        new_pin  = pin_r;
      end
      KIND_EVENTS: begin
        new_rise = up_r;
        new_fall = dn_r;
      end
      KIND_SCAN: begin
        new_lvl = level_r[bit_r];
        upd     = 1'b1;
      end
      KIND_WRITE: begin
        new_lvl = value_r;
        upd     = 1'b1;
      end
      KIND_TOGGLE: begin
        new_lvl = ~old_lvl;
        upd     = 1'b1;
      end
      default: begin
        new_lvl = old_lvl;
      end
    endcase
  end

  assign new_entry  = {new_lvl, new_rise, new_fall, new_port, new_pin};
  assign rise_e     = upd && !old_lvl && new_lvl;
  assign fall_e     = upd && old_lvl && !new_lvl;
  assign ev         = (rise_e && (old_rise != none_code_r))
                   || (fall_e && (old_fall != none_code_r));
  assign code_wide  = rise_e ? WORD_W'(old_rise) : WORD_W'(old_fall);
  assign ev_code    = ev ? code_wide[CODE_W-1:0] : '0;
  assign has_result = !is_scan || ev;

  // pending result word, held until the next one shows whether it is last
  logic              pend_vld_r;
  logic              pend_vld_nxt;
  logic              pend_ev_r;
  logic [CODE_W-1:0] pend_code_r;
  logic              pend_lvl_r;
  logic [PORT_W-1:0] pend_port_r;
  logic [PIN_W-1:0]  pend_pin_r;
  logic              pend_load;

  assign pend_load = cmd.commit && has_result;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (pend_load) begin
      pend_vld_nxt = 1'b1;
    end else if (cmd.flush) begin
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_ev_r   <= ev;
      pend_code_r <= ev_code;
      pend_lvl_r  <= new_lvl;
      pend_port_r <= new_port;
      pend_pin_r  <= new_pin;
    end
  end

  // output register
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_ev_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_lvl_r;
  logic [PORT_W-1:0] out_port_r;
  logic [PIN_W-1:0]  out_pin_r;
  logic              out_last_r;
  logic              push;

  assign push = (pend_load && pend_vld_r) || cmd.flush;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_ev_r   <= pend_ev_r;
      out_code_r <= pend_code_r;
      out_lvl_r  <= pend_lvl_r;
      out_port_r <= pend_port_r;
      out_pin_r  <= pend_pin_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_has_event  = out_ev_r;
  assign out_event_code = out_code_r;
  assign out_level      = out_lvl_r;
  assign out_drive_port = out_port_r;
  assign out_drive_pin  = out_pin_r;
  assign out_last       = out_last_r;

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.is_scan    = is_scan;
    sts.item_ok    = item_ok;
    sts.bit_active = status_r[bit_r] && pmap_vld_r[slot];
    sts.bit_last   = bit_last;
    sts.out_free   = !out_valid_r || out_ready;
    sts.pend_vld   = pend_vld_r;
  end

  `GED_ASSERT_SAME(a_push_free, clk, rst_n, push && out_valid_r, out_ready, "result word overwritten before taken")
  `GED_ASSERT_NEXT(a_flush_drains, clk, rst_n, cmd.flush, !pend_vld_r, "pending word kept after flush")
  `GED_ASSERT_SAME(a_single_pend, clk, rst_n, cmd.commit && !is_scan, !pend_vld_r, "pending word left over from earlier item")

endmodule

### rtl/core/gpio_edge_event_dispatcher.sv
// channel   direction  handshake          carries
// in_ch     in         valid / ready      one item: kind, port, pin, id, value, status, levels, codes
// out_ch    out        valid / ready      one result word: event, code, level, drive place, last
// cfg_ch    in         valid / ready      none-code register write data
//
// map, set-events, write, toggle and read items go from accept through the check, update and final steps.
// a scan walks the port's status bits one bit per cycle, pausing at each set and mapped bit
// for the pin map then line memory read and the update step of that line.
// one item is worked at a time; in_ch is ready only while no item is in progress.
// rst_n is synchronous; it clears all pin map and line valid bits and the none code at once.
// a stalled out_ch holds the block in its update or final step until the word is taken.
module gpio_edge_event_dispatcher #(
  parameter int NUM_LINES     = 64,
  parameter int NUM_PORTS     = 4,
  parameter int PINS_PER_PORT = 32,
  parameter int CODE_WIDTH    = 8
) (
  input logic       clk,
  input logic       rst_n,
  ged_in_if.sink    in_ch,
  ged_out_if.source out_ch,
  ged_cfg_if.sink   cfg_ch
);
  import ged_pkg::*;

  ged_cmd_t cmd;
  ged_sts_t sts;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  // sequencer
  ged_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // maps, line store and result registers
  ged_dp #(
    .NUM_LINES     (NUM_LINES),
    .NUM_PORTS     (NUM_PORTS),
    .PINS_PER_PORT (PINS_PER_PORT),
    .CODE_WIDTH    (CODE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_port        (in_ch.port),
    .in_pin         (in_ch.pin),
    .in_id          (in_ch.id),
    .in_value       (in_ch.value),
    .in_status_bits (in_ch.status_bits),
    .in_level_bits  (in_ch.level_bits),
    .in_up_code     (in_ch.up_code),
    .in_dn_code     (in_ch.dn_code),
    .cfg_valid      (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_has_event  (out_ch.has_event),
    .out_event_code (out_ch.event_code),
    .out_level      (out_ch.level),
    .out_drive_port (out_ch.drive_port),
    .out_drive_pin  (out_ch.drive_pin),
    .out_last       (out_ch.last)
  );

endmodule

### tb/gpio_edge_event_dispatcher_tb.sv
module gpio_edge_event_dispatcher_tb;
  import ged_pkg::*;

  // kinds the block must ignore
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int IDLE_PCT      = 27;
  localparam int DRAIN_CYCLES  = 150;
  localparam int PHASE_ITEMS   = 28;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
    logic [ID_W-1:0]   id;
    logic              value;
    logic [WORD_W-1:0] status_bits;
    logic [WORD_W-1:0] level_bits;
    logic [CODE_W-1:0] up_code;
    logic [CODE_W-1:0] dn_code;
  } item_t;

  typedef struct packed {
    logic              has_event;
    logic [CODE_W-1:0] event_code;
    logic              level;
    logic [PORT_W-1:0] drive_port;
    logic [PIN_W-1:0]  drive_pin;
    logic              last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ged_in_if  in_ch();
  ged_out_if out_ch();
  ged_cfg_if cfg_ch();

  gpio_edge_event_dispatcher dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow of the pin map and line table
  logic              map_ok    [128];
  logic [ID_W-1:0]   map_line  [128];
  logic              line_lvl  [64];
  logic [CODE_W-1:0] rise_tab  [64];
  logic [CODE_W-1:0] fall_tab  [64];
  logic [PORT_W-1:0] home_port [64];
  logic [PIN_W-1:0]  home_pin  [64];
  logic [CODE_W-1:0] none_reg;

  item_t pending_items [$];
  word_t expected_words [$];
  item_t held;
  logic  steady;
  int    bad_words;

  // pins mapped by generated items, to aim scan status bits
  logic [31:0] mapped_mask [4];

  // set a line level, report an edge that has a configured code
  function automatic logic line_edge(input logic [ID_W-1:0] ln, input logic lv,
                                     output logic [CODE_W-1:0] code);
    logic old;
    old = line_lvl[ln];
    line_lvl[ln] = lv;
    code = '0;
    if (!old && lv && rise_tab[ln] != none_reg) begin
      code = rise_tab[ln];
      return 1'b1;
    end
    if (old && !lv && fall_tab[ln] != none_reg) begin
      code = fall_tab[ln];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_word(input logic [ID_W-1:0] ln, input logic ev,
                                    input logic [CODE_W-1:0] code);
    word_t w;
    w.has_event  = ev;
    w.event_code = ev ? code : '0;
    w.level      = line_lvl[ln];
    w.drive_port = home_port[ln];
    w.drive_pin  = home_pin[ln];
    w.last       = 1'b0;
    expected_words.push_back(w);
  endfunction

  // expected words of one accepted item
  function automatic void predict_words(input item_t it);
    logic [CODE_W-1:0] code;
    logic              ev;
    logic [6:0]        slot;
    int                hits;
    int                b;
    code = '0;
    ev   = 1'b0;
    hits = 0;
    if (it.kind == KIND_SCAN) begin
      // walk status bits from bit 0 up
      for (b = 0; b < 32; b++) begin
        slot = {it.port, b[4:0]};
        if (it.status_bits[b[4:0]] && map_ok[slot]) begin
          if (line_edge(map_line[slot], it.level_bits[b[4:0]], code)) begin
            push_word(map_line[slot], 1'b1, code);
            hits++;
          end
        end
      end
      if (hits > 0) expected_words[expected_words.size()-1].last = 1'b1;
      return;
    end
    if (it.kind > KIND_READ) return;
    case (it.kind)
      KIND_MAP: begin
        slot = {it.port, it.pin};
        map_ok[slot]      = 1'b1;
        map_line[slot]    = it.id;
        home_port[it.id]  = it.port;
        home_pin[it.id]   = it.pin;
        rise_tab[it.id]   = none_reg;
        fall_tab[it.id]   = none_reg;
        line_lvl[it.id]   = it.value;
      end
      KIND_EVENTS: begin
        rise_tab[it.id] = it.up_code;
        fall_tab[it.id] = it.dn_code;
      end
      KIND_WRITE:  ev = line_edge(it.id, it.value, code);
      KIND_TOGGLE: ev = line_edge(it.id, !line_lvl[it.id], code);
      default: ;
    endcase
    push_word(it.id, ev, code);
    expected_words[expected_words.size()-1].last = 1'b1;
  endfunction

  // input driver
  always @(posedge clk) begin
    logic take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_words(held);
      take = !in_ch.valid || in_ch.ready;
      if (take) begin
        if (pending_items.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          held = pending_items.pop_front();
          in_ch.kind        <= held.kind;
          in_ch.port        <= held.port;
          in_ch.pin         <= held.pin;
          in_ch.id          <= held.id;
          in_ch.value       <= held.value;
          in_ch.status_bits <= held.status_bits;
          in_ch.level_bits  <= held.level_bits;
          in_ch.up_code     <= held.up_code;
          in_ch.dn_code     <= held.dn_code;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_word(input string what, input word_t want, input word_t got);
    bad_words++;
    if (bad_words <= REPORT_LIMIT) begin
      $display("%s: exp ev=%0b code=%02h lvl=%0b port=%0d pin=%0d last=%0b", what,
               want.has_event, want.event_code, want.level, want.drive_port, want.drive_pin,
               want.last);
      $display("  got ev=%0b code=%02h lvl=%0b port=%0d pin=%0d last=%0b",
               got.has_event, got.event_code, got.level, got.drive_port, got.drive_pin,
               got.last);
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.has_event, out_ch.event_code, out_ch.level, out_ch.drive_port,
               out_ch.drive_pin, out_ch.last};
        if (expected_words.size() == 0) begin
          report_word("unexpected word", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) report_word("word mismatch", want, got);
        end
      end
    end
  end

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [PORT_W-1:0] port,
                            input logic [PIN_W-1:0] pin, input logic [ID_W-1:0] id,
                            input logic value, input logic [WORD_W-1:0] status_bits,
                            input logic [WORD_W-1:0] level_bits,
                            input logic [CODE_W-1:0] up_code,
                            input logic [CODE_W-1:0] dn_code);
    item_t it;
    it = {kind, port, pin, id, value, status_bits, level_bits, up_code, dn_code};
    pending_items.push_back(it);
  endtask

  function automatic item_t random_item(input logic [CODE_W-1:0] none_now);
    item_t it;
    int    pick;
    it.port        = PORT_W'($urandom_range(3));
    it.pin         = PIN_W'($urandom_range(31));
    it.id          = ID_W'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15));
    it.value       = 1'($urandom_range(1));
    it.status_bits = $urandom;
    it.level_bits  = $urandom;
    it.up_code     = CODE_W'($urandom_range(255));
    it.dn_code     = CODE_W'($urandom_range(255));
    pick = int'($urandom_range(99));
    if (pick < 15) begin
      it.kind = KIND_MAP;
      mapped_mask[it.port][it.pin] = 1'b1;
    end else if (pick < 32) begin
      it.kind = KIND_EVENTS;
      // sometimes a code that means no event
      if ($urandom_range(4) == 0) it.up_code = none_now;
      if ($urandom_range(4) == 0) it.dn_code = none_now;
    end else if (pick < 65) begin
      it.kind = KIND_SCAN;
      // mostly aim at mapped pins, sometimes raw noise
      if ($urandom_range(4) != 0) it.status_bits = $urandom & mapped_mask[it.port];
    end else if (pick < 78) begin
      it.kind = KIND_WRITE;
    end else if (pick < 88) begin
      it.kind = KIND_TOGGLE;
    end else if (pick < 95) begin
      it.kind = KIND_READ;
    end else begin
      it.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    end
    return it;
  endfunction

  // none-code register write, block idle
  task automatic set_none_code(input logic [CODE_W-1:0] v);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    none_reg = v;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_words.size() != 0);
    // a scan with no event may still be walking
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [CODE_W-1:0] phase_none [4];
    int p;
    int k;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.port = '0;
    in_ch.pin = '0;
    in_ch.id = '0;
    in_ch.value = 1'b0;
    in_ch.status_bits = '0;
    in_ch.level_bits = '0;
    in_ch.up_code = '0;
    in_ch.dn_code = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    steady = 1'b0;
    bad_words = 0;
    none_reg = '0;
    for (k = 0; k < 128; k++) begin
      map_ok[k[6:0]] = 1'b0;
      map_line[k[6:0]] = '0;
    end
    for (k = 0; k < 64; k++) begin
      line_lvl[k[5:0]] = 1'b0;
      rise_tab[k[5:0]] = '0;
      fall_tab[k[5:0]] = '0;
      home_port[k[5:0]] = '0;
      home_pin[k[5:0]] = '0;
    end
    for (k = 0; k < 4; k++) mapped_mask[k[1:0]] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_none_code(8'h00);

    // never-mapped lines read and driven
    queue_item(KIND_READ,   2'd0, 5'd0,  6'd0,  1'b0, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_WRITE,  2'd0, 5'd0,  6'd63, 1'b1, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_TOGGLE, 2'd0, 5'd0,  6'd63, 1'b0, '0, '0, 8'h00, 8'h00);
    // extreme places
    queue_item(KIND_MAP,    2'd3, 5'd31, 6'd63, 1'b1, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_MAP,    2'd0, 5'd0,  6'd0,  1'b0, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_EVENTS, 2'd0, 5'd0,  6'd0,  1'b0, '0, '0, 8'hFF, 8'h01);
    queue_item(KIND_EVENTS, 2'd0, 5'd0,  6'd63, 1'b0, '0, '0, 8'h00, 8'hAA);
    // full status word, only one pin mapped
    queue_item(KIND_SCAN,   2'd0, 5'd0,  6'd0,  1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               8'h00, 8'h00);
    queue_item(KIND_SCAN,   2'd3, 5'd0,  6'd0,  1'b0, 32'h8000_0000, 32'h0000_0000,
               8'h00, 8'h00);
    // rise whose code equals none code
    queue_item(KIND_SCAN,   2'd3, 5'd0,  6'd0,  1'b0, 32'h8000_0000, 32'h8000_0000,
               8'h00, 8'h00);
    queue_item(KIND_SCAN,   2'd1, 5'd0,  6'd0,  1'b0, 32'h0000_0000, 32'hFFFF_FFFF,
               8'h00, 8'h00);
    // remap, old pin entry still names the line
    queue_item(KIND_MAP,    2'd2, 5'd5,  6'd0,  1'b1, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_EVENTS, 2'd0, 5'd0,  6'd0,  1'b0, '0, '0, 8'h55, 8'h66);
    queue_item(KIND_SCAN,   2'd0, 5'd0,  6'd0,  1'b0, 32'h0000_0001, 32'h0000_0000,
               8'h00, 8'h00);
    queue_item(KIND_WRITE,  2'd0, 5'd0,  6'd0,  1'b1, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_TOGGLE, 2'd0, 5'd0,  6'd0,  1'b0, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_READ,   2'd0, 5'd0,  6'd0,  1'b0, '0, '0, 8'h00, 8'h00);
    // unused kinds
    queue_item(KIND_SPARE_LO, 2'd3, 5'd31, 6'd63, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               8'hFF, 8'hFF);
    queue_item(KIND_SPARE_HI, 2'd1, 5'd7,  6'd1,  1'b0, 32'h0000_FFFF, 32'hFFFF_0000,
               8'h12, 8'h34);
    // two events in one scan
    queue_item(KIND_MAP,    2'd1, 5'd0,  6'd1,  1'b0, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_MAP,    2'd1, 5'd31, 6'd2,  1'b0, '0, '0, 8'h00, 8'h00);
    queue_item(KIND_EVENTS, 2'd0, 5'd0,  6'd1,  1'b0, '0, '0, 8'h11, 8'h12);
    queue_item(KIND_EVENTS, 2'd0, 5'd0,  6'd2,  1'b0, '0, '0, 8'h21, 8'h22);
    queue_item(KIND_SCAN,   2'd1, 5'd0,  6'd0,  1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               8'h00, 8'h00);
    queue_item(KIND_WRITE,  2'd0, 5'd0,  6'd5,  1'b0, '0, '0, 8'h00, 8'h00);
    mapped_mask[0][0] = 1'b1;
    mapped_mask[1][0] = 1'b1;
    mapped_mask[1][31] = 1'b1;
    mapped_mask[2][5] = 1'b1;
    mapped_mask[3][31] = 1'b1;
    wait_drained();

    // random phases over several none codes
    phase_none[0] = 8'hFF;
    phase_none[1] = CODE_W'($urandom_range(254, 1));
    phase_none[2] = 8'h00;
    phase_none[3] = 8'h55;
    for (p = 0; p < 4; p++) begin
      set_none_code(phase_none[p[1:0]]);
      steady = (p == 2);
      for (k = 0; k < PHASE_ITEMS; k++) pending_items.push_back(random_item(phase_none[p[1:0]]));
      wait_drained();
    end

    if (bad_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
